@@ design/hs_pkg.sv @@
// shared types and constants for the heap sort engine
package hs_pkg;

    localparam int DATA_W = 32;

    // register index carried on paddr[2]
    localparam logic REG_ORDER_MODE = 1'b0;

    // order_mode after reset: min-heap, descending output
    localparam logic MODE_RESET = 1'b1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_BLD_NEXT,
        S_BLD_LD,
        S_SIFT_L,
        S_SIFT_LW,
        S_SIFT_RW,
        S_SIFT_DEC,
        S_SORT_NEXT,
        S_SORT_RD0,
        S_SORT_WR,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

endpackage

@@ design/hs_cmp.sv @@
// shared rank comparator: true when a belongs nearer the heap root than b
module hs_cmp (
    input  logic signed [hs_pkg::DATA_W-1:0] a,
    input  logic signed [hs_pkg::DATA_W-1:0] b,
    input  logic                             min_heap,
    output logic                             above
);

    logic a_lt_b;
    logic a_gt_b;

    assign a_lt_b = (a < b);
    assign a_gt_b = (a > b);
    assign above  = min_heap ? a_lt_b : a_gt_b;

endmodule

@@ design/heap_sort_engine.sv @@
// heap sort engine top level: load, in-place heap sort, sorted emission
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------
//   input    | in_valid / in_stall | value, last
//   result   | out_valid/out_stall | sorted_value, final_res, dropped
//   config   | apb psel/penable    | paddr, pwdata, prdata (order_mode)
//
// loading takes one cycle per word; the block stays ready until a word marked last
// sorting then runs on one element memory and one comparator: a sift level steps through
// S_SIFT_L, S_SIFT_LW, S_SIFT_RW (right child only) and S_SIFT_DEC; an extraction adds
// S_SORT_NEXT, S_SORT_RD0 and S_SORT_WR; emission reads and loads each word, waiting
// while the result side stalls; in_stall stays high from the last word until the final
// sorted word is loaded; reset clears control state; the element memory is never cleared
module heap_sort_engine #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [hs_pkg::DATA_W-1:0] value,
    input  logic                             last,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [hs_pkg::DATA_W-1:0] sorted_value,
    output logic                             final_res,
    output logic                             dropped,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;  // memory address
    localparam int CW = $clog2(MAX_ITEMS + 1);                    // element count
    localparam int LW = AW + 2;                                   // child index
    localparam int DW = hs_pkg::DATA_W;

    // element memory, one write and one registered read per cycle
    logic signed [DW-1:0] mem [MAX_ITEMS];
    logic signed [DW-1:0] rd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic signed [DW-1:0] mem_wdata;

    hs_pkg::state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic                 mode_cfg_reg, mode_cfg_next;
    logic                 mode_reg, mode_next;
    logic [AW-1:0]        node_reg, node_next;
    logic [CW-1:0]        size_reg, size_next;
    logic [CW-1:0]        idx_reg, idx_next;        // build index, heap end, emit index
    logic signed [DW-1:0] cur_reg, cur_next;        // value being sifted down
    logic signed [DW-1:0] best_val_reg, best_val_next;
    logic [AW-1:0]        best_idx_reg, best_idx_next;
    logic                 best_child_reg, best_child_next;
    logic                 sorting_reg, sorting_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [DW-1:0] out_val_reg, out_val_next;
    logic                 out_final_reg, out_final_next;
    logic                 out_drop_reg, out_drop_next;

    logic                 in_acc;
    logic                 out_free;
    logic                 cfg_wr;
    logic [CW-1:0]        n_load;
    logic [LW-1:0]        left_w;
    logic [LW-1:0]        right_w;
    logic [LW-1:0]        size_w;
    logic                 left_ok;
    logic                 right_ok;
    logic [CW-1:0]        idx_m1;
    logic                 emit_last;
    logic signed [DW-1:0] cmp_b;
    logic                 cmp_above;

    assign in_stall  = (state_reg != hs_pkg::S_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_wr    = psel && penable && pwrite && pready;

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_val_reg;
    assign final_res    = out_final_reg;
    assign dropped      = out_drop_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == hs_pkg::REG_ORDER_MODE) ? {31'd0, mode_cfg_reg} : 32'd0;

    // set size including the word taken now when it still fits
    assign n_load = (count_reg < CW'(MAX_ITEMS)) ? count_reg + CW'(1) : count_reg;

    // children of the current node
    assign left_w   = {1'b0, node_reg, 1'b1};
    assign right_w  = left_w + LW'(1);
    assign size_w   = LW'(size_reg);
    assign left_ok  = (left_w < size_w);
    assign right_ok = (right_w < size_w);

    assign idx_m1    = idx_reg - CW'(1);
    assign emit_last = ((idx_reg + CW'(1)) == count_reg);

    // the one compare unit: child against the value sifted or the best so far
    assign cmp_b = (state_reg == hs_pkg::S_SIFT_RW) ? best_val_reg : cur_reg;

    hs_cmp u_cmp (
        .a        (rd_data_reg),
        .b        (cmp_b),
        .min_heap (mode_reg),
        .above    (cmp_above)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hs_pkg::S_LOAD:
            begin
                if (in_acc && last)
                begin
                    state_next = hs_pkg::S_BLD_NEXT;
                end
            end
            hs_pkg::S_BLD_NEXT:
            begin
                state_next = (idx_reg == '0) ? hs_pkg::S_SORT_NEXT : hs_pkg::S_BLD_LD;
            end
            hs_pkg::S_BLD_LD:
            begin
                state_next = hs_pkg::S_SIFT_L;
            end
            hs_pkg::S_SIFT_L:
            begin
                if (left_ok)
                begin
                    state_next = hs_pkg::S_SIFT_LW;
                end
                else
                begin
                    state_next = sorting_reg ? hs_pkg::S_SORT_NEXT : hs_pkg::S_BLD_NEXT;
                end
            end
            hs_pkg::S_SIFT_LW:
            begin
                state_next = right_ok ? hs_pkg::S_SIFT_RW : hs_pkg::S_SIFT_DEC;
            end
            hs_pkg::S_SIFT_RW:
            begin
                state_next = hs_pkg::S_SIFT_DEC;
            end
            hs_pkg::S_SIFT_DEC:
            begin
                if (best_child_reg)
                begin
                    state_next = hs_pkg::S_SIFT_L;
                end
                else
                begin
                    state_next = sorting_reg ? hs_pkg::S_SORT_NEXT : hs_pkg::S_BLD_NEXT;
                end
            end
            hs_pkg::S_SORT_NEXT:
            begin
                state_next = (idx_reg <= CW'(1)) ? hs_pkg::S_EMIT_RD : hs_pkg::S_SORT_RD0;
            end
            hs_pkg::S_SORT_RD0:
            begin
                state_next = hs_pkg::S_SORT_WR;
            end
            hs_pkg::S_SORT_WR:
            begin
                state_next = hs_pkg::S_SIFT_L;
            end
            hs_pkg::S_EMIT_RD:
            begin
                if (out_free)
                begin
                    state_next = hs_pkg::S_EMIT_LD;
                end
            end
            hs_pkg::S_EMIT_LD:
            begin
                state_next = emit_last ? hs_pkg::S_LOAD : hs_pkg::S_EMIT_RD;
            end
            default:
            begin
                state_next = hs_pkg::S_LOAD;
            end
        endcase
    end

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = node_reg;
        mem_wdata = cur_reg;
        mem_raddr = left_w[AW-1:0];
        unique case (state_reg)
            hs_pkg::S_LOAD:
            begin
                mem_waddr = count_reg[AW-1:0];
                mem_wdata = value;
                mem_we    = in_acc && (count_reg < CW'(MAX_ITEMS));
            end
            hs_pkg::S_BLD_NEXT:
            begin
                mem_raddr = idx_m1[AW-1:0];
            end
            hs_pkg::S_SIFT_L:
            begin
                mem_raddr = left_w[AW-1:0];
                mem_we    = !left_ok;
            end
            hs_pkg::S_SIFT_LW:
            begin
                mem_raddr = right_w[AW-1:0];
            end
            hs_pkg::S_SIFT_DEC:
            begin
                mem_we    = 1'b1;
                mem_wdata = best_child_reg ? best_val_reg : cur_reg;
            end
            hs_pkg::S_SORT_NEXT:
            begin
                mem_raddr = idx_m1[AW-1:0];
            end
            hs_pkg::S_SORT_RD0:
            begin
                mem_raddr = '0;
            end
            hs_pkg::S_SORT_WR:
            begin
                // old root goes to the end of the shrinking heap
                mem_we    = 1'b1;
                mem_waddr = idx_m1[AW-1:0];
                mem_wdata = rd_data_reg;
            end
            hs_pkg::S_EMIT_RD:
            begin
                mem_raddr = idx_reg[AW-1:0];
            end
            hs_pkg::S_BLD_LD, hs_pkg::S_SIFT_RW, hs_pkg::S_EMIT_LD:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        mode_cfg_next   = mode_cfg_reg;
        mode_next       = mode_reg;
        node_next       = node_reg;
        size_next       = size_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        best_child_next = best_child_reg;
        sorting_next    = sorting_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_val_next    = out_val_reg;
        out_final_next  = out_final_reg;
        out_drop_next   = out_drop_reg;

        if (cfg_wr && (paddr[2] == hs_pkg::REG_ORDER_MODE))
        begin
            mode_cfg_next = pwdata[0];
        end

        unique case (state_reg)
            hs_pkg::S_LOAD:
            begin
                if (in_acc)
                begin
                    count_next = n_load;
                    if (count_reg == CW'(MAX_ITEMS))
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        size_next    = n_load;
                        idx_next     = n_load >> 1;
                        mode_next    = mode_cfg_reg;
                        sorting_next = 1'b0;
                    end
                end
            end
            hs_pkg::S_BLD_NEXT:
            begin
                if (idx_reg == '0)
                begin
                    sorting_next = 1'b1;
                    idx_next     = count_reg;
                end
                else
                begin
                    node_next = idx_m1[AW-1:0];
                    idx_next  = idx_m1;
                end
            end
            hs_pkg::S_BLD_LD:
            begin
                cur_next = rd_data_reg;
            end
            hs_pkg::S_SIFT_LW:
            begin
                best_idx_next   = left_w[AW-1:0];
                best_child_next = cmp_above;
                best_val_next   = cmp_above ? rd_data_reg : cur_reg;
            end
            hs_pkg::S_SIFT_RW:
            begin
                if (cmp_above)
                begin
                    best_idx_next   = right_w[AW-1:0];
                    best_child_next = 1'b1;
                    best_val_next   = rd_data_reg;
                end
            end
            hs_pkg::S_SIFT_DEC:
            begin
                if (best_child_reg)
                begin
                    node_next = best_idx_reg;
                end
            end
            hs_pkg::S_SORT_NEXT:
            begin
                if (idx_reg <= CW'(1))
                begin
                    idx_next = '0;
                end
            end
            hs_pkg::S_SORT_RD0:
            begin
                cur_next = rd_data_reg;
            end
            hs_pkg::S_SORT_WR:
            begin
                size_next = idx_m1;
                idx_next  = idx_m1;
                node_next = '0;
            end
            hs_pkg::S_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_val_next   = rd_data_reg;
                out_final_next = emit_last;
                out_drop_next  = ovf_reg;
                idx_next       = idx_reg + CW'(1);
                if (emit_last)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            hs_pkg::S_SIFT_L, hs_pkg::S_EMIT_RD:
            begin
                cur_next = cur_reg;
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hs_pkg::S_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            mode_cfg_reg   <= hs_pkg::MODE_RESET;
            mode_reg       <= hs_pkg::MODE_RESET;
            sorting_reg    <= 1'b0;
            best_child_reg <= 1'b0;
            idx_reg        <= '0;
            size_reg       <= '0;
            node_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            mode_cfg_reg   <= mode_cfg_next;
            mode_reg       <= mode_next;
            sorting_reg    <= sorting_next;
            best_child_reg <= best_child_next;
            idx_reg        <= idx_next;
            size_reg       <= size_next;
            node_reg       <= node_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        best_val_reg  <= best_val_next;
        best_idx_reg  <= best_idx_next;
        out_val_reg   <= out_val_next;
        out_final_reg <= out_final_next;
        out_drop_reg  <= out_drop_next;
    end

endmodule

@@ design/hs_checker.sv @@
// port-level checks for the heap sort engine, bound to the top level
module hs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             last,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [hs_pkg::DATA_W-1:0] sorted_value,
    input logic                             final_res
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sorted_value) && $stable(final_res))
        else $error("stalled result word changed");

    // a word that is not last keeps the input side open
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last |=> !in_stall)
        else $error("input closed after a word not marked last");

    // the last word starts the sort and closes the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("input still open after the last word");

    // while a set is emitted no new word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !final_res |-> in_stall)
        else $error("input open during emission");

endmodule

bind heap_sort_engine hs_checker u_hs_checker (.*);
